// ===== rtl/core/ivc_pkg.sv =====
// Shared widths and payload types of the inversion vector counter.
package ivc_pkg;

    localparam int VALUE_W = 10;
    localparam int COUNT_W = 10;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== rtl/core/ivc_in_if.sv =====
// Input channel of the inversion vector counter: valid, ready, value and last.
interface ivc_in_if;

    logic            valid;
    logic            ready;
    ivc_pkg::value_t value;
    logic            last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

// ===== rtl/core/ivc_out_if.sv =====
// Result channel of the inversion vector counter: valid, ready and count.
interface ivc_out_if;

    logic            valid;
    logic            ready;
    ivc_pkg::count_t count;

    modport source (output valid, output count, input ready);
    modport sink   (input valid, input count, output ready);

endinterface

// ===== rtl/core/inversion_vector_counter.sv =====
// An accepted value gives its count after the level RAM read and then the read-modify-write
// plus adder tree; a new value is taken only once the current one has gone through both.
// An item marked last is followed by a clearing sweep over 2^(VALUE_BITS-1) entries
// (512 at the defaults), one entry per level per cycle, with the input held off.
// Reset (rst_n, asynchronous, active low) starts the same clearing sweep.
// A finished count waits in an output register; a new value needs it free or draining.
module inversion_vector_counter #(
    parameter int VALUE_BITS = 10,
    parameter int MAX_LEN    = 1024
) (
    input  logic clk,
    input  logic rst_n,
    ivc_in_if.sink    item,
    ivc_out_if.source result
);

    import ivc_pkg::*;

    // Counter width follows the saturation limit MAX_LEN - 1.
    localparam int CNT_W     = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam int NLEAF     = 1 << $clog2(VALUE_BITS);
    localparam int SUM_W     = CNT_W + $clog2(VALUE_BITS) + 1;
    localparam int CLR_W     = (VALUE_BITS > 1) ? VALUE_BITS - 1 : 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_LEN - 1);
    localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'((1 << (VALUE_BITS - 1)) - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } state_t;

    state_t                  state_reg;
    logic [CLR_W-1:0]        clr_reg;
    logic [VALUE_BITS-1:0]   val_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    logic [CNT_W-1:0]        count_reg;

    logic [VALUE_BITS-1:0]   in_val;
    logic                    accept;
    logic [CNT_W-1:0]        count_next;

    logic [CNT_W-1:0]        lvl_rdata [VALUE_BITS];
    logic [SUM_W-1:0]        tree      [1:2*NLEAF-1];

    // Keep the low VALUE_BITS bits of the input value; zero-fill when wider.
    generate
        if (VALUE_BITS <= VALUE_W)
        begin : g_val_narrow
            assign in_val = item.value[VALUE_BITS-1:0];
        end
        else
        begin : g_val_wide
            assign in_val = VALUE_BITS'(item.value);
        end
    endgenerate

    // Take a new value only when idle and the output slot is free or draining.
    assign item.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;

    // One counter bank per bit level k, addressed by value >> (k+1).
    // A set bit k increments the counter; a clear bit k adds it to the count.
    genvar k;
    generate
        for (k = 0; k < VALUE_BITS; k++)
        begin : g_level
            localparam int LVL_DEPTH = 1 << (VALUE_BITS - k - 1);
            localparam int LVL_AW    = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;

            logic [VALUE_BITS-1:0] rd_shift;
            logic [VALUE_BITS-1:0] wr_shift;
            logic [LVL_AW-1:0]     raddr;
            logic [LVL_AW-1:0]     waddr;
            logic [CNT_W-1:0]      wdata;
            logic                  we;

            assign rd_shift = in_val >> (k + 1);
            assign wr_shift = val_reg >> (k + 1);

            always_comb
            begin
                raddr = rd_shift[LVL_AW-1:0];
                if (state_reg == S_CLEAR)
                begin
                    waddr = clr_reg[LVL_AW-1:0];
                    wdata = '0;
                    we    = 1'b1;
                end
                else
                begin
                    waddr = wr_shift[LVL_AW-1:0];
                    // Saturate the increment at the limit.
                    wdata = (lvl_rdata[k] == COUNT_MAX) ? COUNT_MAX
                                                        : lvl_rdata[k] + CNT_W'(1);
                    we    = (state_reg == S_CALC) && val_reg[k];
                end
            end

            ivc_ram #(
                .WIDTH (CNT_W),
                .DEPTH (LVL_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (we),
                .waddr (waddr),
                .wdata (wdata),
                .raddr (raddr),
                .rdata (lvl_rdata[k])
            );
        end
    endgenerate

    // Adder tree over the contributions of the levels whose bit is clear.
    genvar n;
    generate
        for (n = 0; n < NLEAF; n++)
        begin : g_leaf
            if (n < VALUE_BITS)
            begin : g_used
                assign tree[NLEAF + n] = val_reg[n] ? '0 : SUM_W'(lvl_rdata[n]);
            end
            else
            begin : g_pad
                assign tree[NLEAF + n] = '0;
            end
        end
        for (n = 1; n < NLEAF; n++)
        begin : g_node
            assign tree[n] = tree[2*n] + tree[2*n + 1];
        end
    endgenerate

    // The sum of non-negative terms saturates once, at the end.
    assign count_next = (tree[1] > SUM_W'(COUNT_MAX)) ? COUNT_MAX : tree[1][CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid when a count is formed; drop it once the transaction is taken.
            if (state_reg == S_CALC)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + CLR_W'(1);
                    if (clr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    clr_reg       <= '0;
                    state_reg     <= last_reg ? S_CLEAR : S_IDLE;
                end
                default:
                begin
                    state_reg <= S_CLEAR;
                    clr_reg   <= '0;
                end
            endcase
        end
    end

    // Payload registers: capture the transaction, then the finished count.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            val_reg  <= in_val;
            last_reg <= item.last;
        end
        if (state_reg == S_CALC)
        begin
            count_reg <= count_next;
        end
    end

    assign result.valid = out_valid_reg;

    generate
        if (CNT_W <= COUNT_W)
        begin : g_cnt_narrow
            assign result.count = COUNT_W'(count_reg);
        end
        else
        begin : g_cnt_wide
            assign result.count = count_reg[COUNT_W-1:0];
        end
    endgenerate

    // Every accepted transaction raises result.valid once it has passed through S_CALC.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 result.valid)
        else $error("count missing two cycles after accept");

    // The output slot is free whenever a count is formed.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> !out_valid_reg)
        else $error("pending count overwritten");

    // No value enters while the banks are being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !item.ready)
        else $error("input taken during clearing sweep");

    // A value marked last starts the clearing sweep from entry zero.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && last_reg) |=> (state_reg == S_CLEAR && clr_reg == '0))
        else $error("last value did not start the clearing sweep");

endmodule

// ===== rtl/core/ivc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ivc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 512
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
